>>> hdl/tmsa_pkg.sv
// shared types and constants for the trailing median spike alert block
`default_nettype none
package tmsa_pkg;

  localparam int WINDOW_MAX_DEF = 256;
  localparam int VALUE_BITS_DEF = 16;
  localparam int CFG_W          = 9;
  localparam int COUNT_W        = 32;
  localparam int LEN_RESET      = 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } seq_state_t;

  typedef struct packed {
    logic upd;
    logic do_remove;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/tmsa_ram.sv
// generic single write port ram with registered read
`default_nettype none
module tmsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> hdl/tmsa_cell.sv
// one cell of the sorted chain: remove-and-insert step on its own slot
`default_nettype none
module tmsa_cell import tmsa_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int LEN_W      = 9,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic [LEN_W-1:0]      m,
  input  wire logic [VALUE_BITS-1:0] r,
  input  wire logic [VALUE_BITS-1:0] v,
  input  wire logic [VALUE_BITS-1:0] a_next,
  input  wire logic [VALUE_BITS-1:0] c_prev,
  input  wire logic                  cle_prev,
  output logic      [VALUE_BITS-1:0] a,
  output logic      [VALUE_BITS-1:0] c,
  output logic                       cle
);

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [VALUE_BITS-1:0] a_r;
  logic [VALUE_BITS-1:0] a_nxt;

  // slot after dropping the removed value
  assign c   = (ctrl.do_remove && !(a_r < r)) ? a_next : a_r;
  assign cle = (MY_IDX < m) && (c <= v);

  always_comb begin
    if (cle) begin
      a_nxt = c;
    end else if (cle_prev) begin
      a_nxt = v;
    end else begin
      a_nxt = c_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      a_r <= a_nxt;
    end
  end

  assign a = a_r;

endmodule
`default_nettype wire

>>> hdl/tmsa_chain.sv
// sorted chain of cells with a two-level registered median tap
`default_nettype none
module tmsa_chain import tmsa_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int LEN_W      = 9,
  parameter int IDX_W      = 8
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic [LEN_W-1:0]      m,
  input  wire logic [VALUE_BITS-1:0] r,
  input  wire logic [VALUE_BITS-1:0] v,
  input  wire logic [IDX_W-1:0]      lo_idx,
  input  wire logic [IDX_W-1:0]      hi_idx,
  output logic      [VALUE_BITS-1:0] med_lo,
  output logic      [VALUE_BITS-1:0] med_hi
);

  localparam int LO_W = IDX_W / 2;
  localparam int HI_W = IDX_W - LO_W;
  localparam int NPAD = 2 ** IDX_W;
  localparam int NGRP = 2 ** HI_W;

  logic [VALUE_BITS-1:0] a   [WINDOW_MAX];
  logic [VALUE_BITS-1:0] c   [WINDOW_MAX];
  logic                  cle [WINDOW_MAX];
  logic [VALUE_BITS-1:0] pad [NPAD];

  logic [VALUE_BITS-1:0] grp_lo_r [NGRP];
  logic [VALUE_BITS-1:0] grp_hi_r [NGRP];
  logic [VALUE_BITS-1:0] med_lo_r;
  logic [VALUE_BITS-1:0] med_hi_r;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [VALUE_BITS-1:0] nb_next;
    logic [VALUE_BITS-1:0] nb_c;
    logic                  nb_cle;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign nb_next = '0;
    end else begin : g_mid
      assign nb_next = a[i+1];
    end

    if (i == 0) begin : g_first
      assign nb_c   = '0;
      assign nb_cle = 1'b1;
    end else begin : g_rest
      assign nb_c   = c[i-1];
      assign nb_cle = cle[i-1];
    end

    tmsa_cell #(
      .VALUE_BITS (VALUE_BITS),
      .LEN_W      (LEN_W),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .m        (m),
      .r        (r),
      .v        (v),
      .a_next   (nb_next),
      .c_prev   (nb_c),
      .cle_prev (nb_cle),
      .a        (a[i]),
      .c        (c[i]),
      .cle      (cle[i])
    );
  end

  for (genvar i = 0; i < NPAD; i++) begin : g_pad
    if (i < WINDOW_MAX) begin : g_real
      assign pad[i] = a[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_lo_r[g] <= pad[{HI_W'(g), lo_idx[LO_W-1:0]}];
      grp_hi_r[g] <= pad[{HI_W'(g), hi_idx[LO_W-1:0]}];
    end
    med_lo_r <= grp_lo_r[lo_idx[IDX_W-1:LO_W]];
    med_hi_r <= grp_hi_r[hi_idx[IDX_W-1:LO_W]];
  end

  assign med_lo = med_lo_r;
  assign med_hi = med_hi_r;

endmodule
`default_nettype wire

>>> hdl/trailing_median_spike_alert.sv
// top level of the trailing median spike alert block
//
// Input stream: in_tdata carries one sample, in_tuser the restart flag that
// empties the window and the alert count before that sample is taken.
// Output stream: one beat per input beat with alert, window_full, twice the
// median of the trailing window and the saturating alert count.
// cfg_wen with cfg_wdata sets the window length (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX) and empties the window; write it while idle.
// Each sample is accepted in S_IDLE, the registered ring ram read of the oldest
// sample is done in S_READ, and in S_EXEC the cell chain removes the oldest value
// and inserts the new one; in_tready is high only in S_IDLE, so a new sample
// is taken only after the last one is through. out_tvalid is set by the S_EXEC update.
// The median comes from a two-level registered tap on the chain.
// A finished result sits in the output register while the next sample is
// accepted and read; if the receiver still stalls, the update step waits.
// After reset the window is empty, the count is zero and the length is 5, capped at WINDOW_MAX.
// No clearing pass is needed: only slots below the fill level are used.
`default_nettype none
module trailing_median_spike_alert import tmsa_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // sample_value
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]        in_tdata,
  // restart
  input  wire logic                                   in_tuser,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // alert, window_full, median_times_two, alert_count
  output logic      [((VALUE_BITS+COUNT_W+10)/8)*8-1:0] out_tdata,
  input  wire logic                                   cfg_wen,
  input  wire logic [CFG_W-1:0]                       cfg_wdata
);

  localparam int OUT_W   = ((VALUE_BITS + COUNT_W + 10) / 8) * 8;
  localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W   = ($clog2(WINDOW_MAX) > 2) ? $clog2(WINDOW_MAX) : 2;
  localparam int NW      = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;
  localparam int CMP_W   = (CFG_W > LEN_W) ? CFG_W : LEN_W;
  localparam int LEN_RST = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

  seq_state_t state_r, state_nxt;

  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      fill_r, fill_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic                  accept;
  logic                  rd_en;
  logic                  exec_fire;
  logic                  full;
  logic                  alert;
  logic [VALUE_BITS:0]   m2;
  logic [VALUE_BITS:0]   m2_out;
  logic [COUNT_W-1:0]    cnt_after;
  logic [NW-1:0]         ptr_inc;
  logic [LEN_W-1:0]      cfg_len;
  logic [LEN_W-1:0]      m;
  logic [IDX_W-1:0]      lo_idx;
  logic [IDX_W-1:0]      hi_idx;
  logic [VALUE_BITS-1:0] oldest;
  logic [VALUE_BITS-1:0] med_lo;
  logic [VALUE_BITS-1:0] med_hi;
  cell_ctrl_t            ctrl;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_EXEC: begin
        exec_fire = !out_valid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_len = LEN_W'(1);
    end else if (CMP_W'(cfg_wdata) > CMP_W'(WINDOW_MAX)) begin
      cfg_len = LEN_W'(WINDOW_MAX);
    end else begin
      cfg_len = LEN_W'(cfg_wdata);
    end
  end

  assign full      = fill_r >= len_r;
  assign m         = full ? len_r - LEN_W'(1) : fill_r;
  assign lo_idx    = IDX_W'((len_r - LEN_W'(1)) >> 1);
  assign hi_idx    = IDX_W'(len_r >> 1);
  assign m2        = {1'b0, med_lo} + {1'b0, med_hi};
  assign alert     = full && ({1'b0, v_r} >= m2);
  assign m2_out    = full ? m2 : '0;
  assign cnt_after = (alert && (cnt_r != '1)) ? cnt_r + COUNT_W'(1) : cnt_r;
  assign ptr_inc   = NW'(ptr_r) + NW'(1);

  assign ctrl.upd       = exec_fire;
  assign ctrl.do_remove = full;

  always_comb begin
    len_nxt  = len_r;
    fill_nxt = fill_r;
    ptr_nxt  = ptr_r;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    if (cfg_wen) begin
      len_nxt  = cfg_len;
      fill_nxt = '0;
      ptr_nxt  = '0;
    end else if (accept) begin
      v_nxt = in_tdata[VALUE_BITS-1:0];
      if (in_tuser) begin
        fill_nxt = '0;
        ptr_nxt  = '0;
        cnt_nxt  = '0;
      end
    end else if (exec_fire) begin
      fill_nxt = full ? fill_r : fill_r + LEN_W'(1);
      ptr_nxt  = (ptr_inc >= NW'(len_r)) ? '0 : IDX_W'(ptr_inc);
      cnt_nxt  = cnt_after;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'({cnt_after, m2_out, full, alert});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_W'(LEN_RST);
      fill_r      <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tmsa_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (2 ** IDX_W),
    .AW    (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (exec_fire),
    .wr_addr (ptr_r),
    .wr_data (v_r),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (oldest)
  );

  tmsa_chain #(
    .WINDOW_MAX (WINDOW_MAX),
    .VALUE_BITS (VALUE_BITS),
    .LEN_W      (LEN_W),
    .IDX_W      (IDX_W)
  ) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .m      (m),
    .r      (oldest),
    .v      (v_r),
    .lo_idx (lo_idx),
    .hi_idx (hi_idx),
    .med_lo (med_lo),
    .med_hi (med_hi)
  );

endmodule
`default_nettype wire

>>> hdl/tmsa_checker.sv
// port-level checker for the trailing median spike alert block, with its bind
`default_nettype none
module tmsa_checker import tmsa_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input wire logic                                     clk,
  input wire logic                                     rst_n,
  input wire logic                                     in_tvalid,
  input wire logic                                     in_tready,
  input wire logic                                     out_tvalid,
  input wire logic                                     out_tready,
  input wire logic [((VALUE_BITS+COUNT_W+10)/8)*8-1:0] out_tdata
);

  // a stalled result beat keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // no result beat straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one sample at a time: no second accept in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // a window that is not full gives no alert and no median
  a_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> !out_tdata[0] && (out_tdata[VALUE_BITS+2:2] == '0))
    else $error("alert or median without a full window");

  // an alert needs a positive count
  a_alert_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[VALUE_BITS+COUNT_W+2:VALUE_BITS+3] != '0))
    else $error("alert with zero count");

endmodule

bind trailing_median_spike_alert tmsa_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_tmsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
